[hdl/cfd_pkg.sv]
package cfd_pkg;

    // Default payload capacity; the top level hands the real value down
    localparam int MAX_PAYLOAD_DEF = 64;

    // Widest length value over the parameter range (up to 1024 bytes)
    localparam int LEN_MAX_W = 11;

    localparam int HEADER_LEN = 6;

    localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
    localparam logic [7:0]  SYNC_SECOND = 8'h5A;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    localparam logic [7:0] VERSION_RST = 8'h02;
    localparam logic [6:0] MAX_LEN_RST = 7'd64;

    // Field widths of the channels
    localparam int BYTE_W   = 8;
    localparam int PLEN_W   = 7;
    localparam int SEQ_W    = 16;
    localparam int IDX_W    = 6;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_VERSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAY_LEN      = 2'd1;

    // Byte positions within the frame header
    localparam int POS_VERSION = 0;
    localparam int POS_TYPE    = 1;
    localparam int POS_LEN_LO  = 2;
    localparam int POS_LEN_HI  = 3;
    localparam int POS_SEQ_LO  = 4;
    localparam int POS_SEQ_HI  = 5;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SYNC,
        PH_BODY,
        PH_CRC_LO,
        PH_CRC_HI
    } ph_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_READ,
        EM_LOAD,
        EM_SHOW
    } em_t;

    typedef struct packed {
        logic [7:0] expected_version;
        logic [6:0] max_pay_len;
    } cfg_t;

    // Handed from parser to emitter when the CRC high byte arrives
    typedef struct packed {
        logic                 start;
        logic                 crc_err;
        logic [7:0]           msg_type;
        logic [LEN_MAX_W-1:0] len;
        logic [SEQ_W-1:0]     seq;
    } frame_t;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hdl/cfd_in_if.sv]
interface cfd_in_if import cfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

[hdl/cfd_out_if.sv]
interface cfd_out_if import cfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              status;
    logic [7:0]        msg_type;
    logic [PLEN_W-1:0] pay_len;
    logic [SEQ_W-1:0]  sequence_number;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last;

    modport source (output valid, output status, output msg_type, output pay_len,
                    output sequence_number, output payload_valid, output payload_byte,
                    output byte_index, output last, input ready);
    modport sink   (input valid, input status, input msg_type, input pay_len,
                    input sequence_number, input payload_valid, input payload_byte,
                    input byte_index, input last, output ready);
endinterface

[hdl/cfd_cfg_if.sv]
interface cfd_cfg_if import cfd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/crc16_frame_deframer_core.sv]
// Channel   Dir   Payload                                         Accepted when
// rx        in    kind, data_byte                                 rx.valid && rx.ready
// tx        out   status, msg_type, pay_len, ...                  tx.valid && tx.ready
// cfg       in    index, data                                     cfg.valid && cfg.ready
//
// Each received byte takes one cycle while no frame is being read out.
// A good frame with N payload bytes gives N results, each read from the
// payload memory, loaded into the result register and then shown; an
// error or empty frame gives one result in the cycle after its last CRC byte.
// rx.ready is low from then until the last result is taken; tx stalls hold it.
// Reset is asynchronous; the payload memory needs no clearing.
module crc16_frame_deframer_core import cfd_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    cfd_in_if.sink    rx,
    cfd_out_if.source tx,
    cfd_cfg_if.sink   cfg
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0] expected_version_reg;
    logic [6:0] max_pay_len_reg;
    cfg_t       cfg_q;
    frame_t     frame;
    logic       emit_busy;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_version_reg <= VERSION_RST;
            max_pay_len_reg      <= MAX_LEN_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_EXPECTED_VERSION: expected_version_reg <= cfg.data;
                REG_MAX_PAY_LEN:      max_pay_len_reg      <= cfg.data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg_q.expected_version = expected_version_reg;
        cfg_q.max_pay_len      = max_pay_len_reg;
    end

    cfd_parser #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW)) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_q),
        .rx        (rx),
        .emit_busy (emit_busy),
        .frame     (frame),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    cfd_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD), .AW(AW)) u_payload_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cfd_emitter #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW)) u_emitter (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame),
        .busy    (emit_busy),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .tx      (tx)
    );

endmodule

[hdl/cfd_ram.sv]
module cfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/cfd_parser.sv]
module cfd_parser import cfd_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    cfd_in_if.sink      rx,
    input  logic        emit_busy,
    output frame_t      frame,
    output logic        wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]  wr_data
);

    localparam int CNT_W = $clog2(HEADER_LEN + MAX_PAYLOAD + 1);

    ph_t                  ph_reg, ph_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [15:0]          crc_reg, crc_next;
    logic [7:0]           crc_lo_reg, crc_lo_next;
    logic [7:0]           ver_reg, ver_next;
    logic [7:0]           type_reg, type_next;
    logic [7:0]           len_lo_reg, len_lo_next;
    logic [LEN_MAX_W-1:0] len_reg, len_next;
    logic [7:0]           seq_lo_reg, seq_lo_next;
    logic [7:0]           seq_hi_reg, seq_hi_next;

    logic             accept;
    logic [7:0]       b;
    logic [15:0]      len16;
    logic [CNT_W-1:0] cnt_inc;
    logic             hdr_ok;
    logic             at_len_hi;

    assign rx.ready  = !emit_busy;
    assign accept    = rx.valid && rx.ready;
    assign b         = rx.data_byte;
    assign len16     = {b, len_lo_reg};
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign at_len_hi = (cnt_reg == CNT_W'(POS_LEN_HI));
    assign hdr_ok    = (ver_reg == cfg.expected_version)
                    && (len16 <= 16'(cfg.max_pay_len))
                    && (32'(len16) <= 32'(MAX_PAYLOAD));

    // Next phase
    always_comb
    begin
        ph_next = ph_reg;
        if (accept)
        begin
            if (rx.kind)
            begin
                ph_next = PH_HUNT;
            end
            else
            begin
                case (ph_reg)
                    PH_HUNT:
                    begin
                        if (b == SYNC_FIRST)
                        begin
                            ph_next = PH_SYNC;
                        end
                    end
                    PH_SYNC:
                    begin
                        if (b == SYNC_SECOND)
                        begin
                            ph_next = PH_BODY;
                        end
                        else if (b != SYNC_FIRST)
                        begin
                            ph_next = PH_HUNT;
                        end
                    end
                    PH_BODY:
                    begin
                        if (at_len_hi && !hdr_ok)
                        begin
                            ph_next = PH_HUNT;
                        end
                        else if (total_reg != '0 && cnt_inc == total_reg)
                        begin
                            ph_next = PH_CRC_LO;
                        end
                    end
                    PH_CRC_LO: ph_next = PH_CRC_HI;
                    PH_CRC_HI: ph_next = PH_HUNT;
                    default:   ph_next = PH_HUNT;
                endcase
            end
        end
    end

    // Body counters, CRC, header capture and payload write
    always_comb
    begin
        logic restart;
        restart     = 1'b0;
        cnt_next    = cnt_reg;
        total_next  = total_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        ver_next    = ver_reg;
        type_next   = type_reg;
        len_lo_next = len_lo_reg;
        len_next    = len_reg;
        seq_lo_next = seq_lo_reg;
        seq_hi_next = seq_hi_reg;
        wr_en       = 1'b0;
        wr_addr     = AW'(cnt_reg - CNT_W'(HEADER_LEN));
        wr_data     = b;

        if (accept)
        begin
            if (rx.kind)
            begin
                restart = 1'b1;
            end
            else
            begin
                case (ph_reg)
                    PH_HUNT:
                    begin
                    end
                    PH_SYNC:
                    begin
                        if (b == SYNC_SECOND || b != SYNC_FIRST)
                        begin
                            restart = 1'b1;
                        end
                    end
                    PH_BODY:
                    begin
                        cnt_next = cnt_inc;
                        crc_next = crc_feed(crc_reg, b);
                        if (cnt_reg == CNT_W'(POS_VERSION))
                        begin
                            ver_next = b;
                        end
                        if (cnt_reg == CNT_W'(POS_TYPE))
                        begin
                            type_next = b;
                        end
                        if (cnt_reg == CNT_W'(POS_LEN_LO))
                        begin
                            len_lo_next = b;
                        end
                        if (cnt_reg == CNT_W'(POS_SEQ_LO))
                        begin
                            seq_lo_next = b;
                        end
                        if (cnt_reg == CNT_W'(POS_SEQ_HI))
                        begin
                            seq_hi_next = b;
                        end
                        if (cnt_reg >= CNT_W'(HEADER_LEN))
                        begin
                            wr_en = 1'b1;
                        end
                        if (at_len_hi)
                        begin
                            if (hdr_ok)
                            begin
                                total_next = CNT_W'(HEADER_LEN) + CNT_W'(len16);
                                len_next   = LEN_MAX_W'(len16);
                            end
                            else
                            begin
                                restart = 1'b1;
                            end
                        end
                    end
                    PH_CRC_LO:
                    begin
                        crc_lo_next = b;
                    end
                    default:
                    begin
                        restart = 1'b1;
                    end
                endcase
            end
        end

        if (restart)
        begin
            cnt_next    = '0;
            total_next  = '0;
            crc_next    = CRC_INIT;
            crc_lo_next = '0;
        end
    end

    always_comb
    begin
        frame.start    = accept && !rx.kind && (ph_reg == PH_CRC_HI);
        frame.crc_err  = ({b, crc_lo_reg} != crc_reg);
        frame.msg_type = type_reg;
        frame.len      = len_reg;
        frame.seq      = {seq_hi_reg, seq_lo_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg     <= PH_HUNT;
            cnt_reg    <= '0;
            total_reg  <= '0;
            crc_reg    <= CRC_INIT;
            crc_lo_reg <= '0;
        end
        else
        begin
            ph_reg     <= ph_next;
            cnt_reg    <= cnt_next;
            total_reg  <= total_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ver_reg    <= ver_next;
        type_reg   <= type_next;
        len_lo_reg <= len_lo_next;
        len_reg    <= len_next;
        seq_lo_reg <= seq_lo_next;
        seq_hi_reg <= seq_hi_next;
    end

endmodule

[hdl/cfd_emitter.sv]
module cfd_emitter import cfd_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  frame_t        frame,
    output logic          busy,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  logic [7:0]    rd_data,
    cfd_out_if.source     tx
);

    em_t                  st_reg, st_next;
    logic [AW-1:0]        k_reg;
    logic                 err_reg;
    logic [7:0]           type_reg;
    logic [LEN_MAX_W-1:0] len_reg;
    logic [SEQ_W-1:0]     seq_reg;
    logic [7:0]           byte_reg;
    logic                 last_reg;
    logic                 taken;

    assign taken = tx.valid && tx.ready;

    // Next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            EM_IDLE:
            begin
                if (frame.start)
                begin
                    if (frame.crc_err || frame.len == '0)
                    begin
                        st_next = EM_SHOW;
                    end
                    else
                    begin
                        st_next = EM_READ;
                    end
                end
            end
            EM_READ: st_next = EM_LOAD;
            EM_LOAD: st_next = EM_SHOW;
            EM_SHOW:
            begin
                if (taken)
                begin
                    st_next = last_reg ? EM_IDLE : EM_READ;
                end
            end
            default: st_next = EM_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        busy                = (st_reg != EM_IDLE);
        rd_en               = (st_reg == EM_READ);
        rd_addr             = k_reg;
        tx.valid            = (st_reg == EM_SHOW);
        tx.status           = err_reg;
        tx.msg_type         = err_reg ? '0 : type_reg;
        tx.pay_len          = err_reg ? '0 : PLEN_W'(len_reg);
        tx.sequence_number  = err_reg ? '0 : seq_reg;
        tx.payload_valid    = !err_reg && (len_reg != '0);
        tx.payload_byte     = byte_reg;
        tx.byte_index       = IDX_W'(k_reg);
        tx.last             = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= EM_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    // Frame fields and the result register
    always_ff @(posedge clk)
    begin
        case (st_reg)
            EM_IDLE:
            begin
                if (frame.start)
                begin
                    err_reg  <= frame.crc_err;
                    type_reg <= frame.msg_type;
                    len_reg  <= frame.len;
                    seq_reg  <= frame.seq;
                    k_reg    <= '0;
                    byte_reg <= '0;
                    last_reg <= frame.crc_err || (frame.len == '0);
                end
            end
            EM_LOAD:
            begin
                byte_reg <= rd_data;
                last_reg <= (LEN_MAX_W'(k_reg) + LEN_MAX_W'(1)) == len_reg;
            end
            EM_SHOW:
            begin
                if (taken && !last_reg)
                begin
                    k_reg <= k_reg + AW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[bench/tb_crc16_frame_deframer_core.sv]
`timescale 1ns / 100ps

module tb_crc16_frame_deframer_core;
    import cfd_pkg::*;

    localparam int PAYLOAD_CAP = MAX_PAYLOAD_DEF;
    localparam int BODY_CAP    = HEADER_LEN + PAYLOAD_CAP;
    localparam int DRAIN_WAIT  = 12;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_RESYNC = 1'b1;
    localparam logic ST_GOOD     = 1'b0;
    localparam logic ST_CRC_ERR  = 1'b1;

    typedef struct packed {
        logic              status;
        logic [7:0]        msg_type;
        logic [PLEN_W-1:0] pay_len;
        logic [SEQ_W-1:0]  sequence_number;
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic [IDX_W-1:0]  byte_index;
        logic              last;
    } deframed_t;

    typedef enum logic [1:0] {
        SRC_LIT,
        SRC_CRC_LO,
        SRC_CRC_HI,
        SRC_CRC_LO_BAD
    } byte_src_t;

    typedef struct packed {
        logic      kind;
        byte_src_t src;
        logic [7:0] lit;
        logic      fixed;
        deframed_t want;
    } script_row_t;

    localparam deframed_t NO_RESULT = '0;
    localparam deframed_t EMPTY_FRAME_FF =
        '{ST_GOOD, 8'hFF, 7'd0, 16'hFFFF, 1'b0, 8'h00, 6'd0, 1'b1};
    localparam deframed_t CRC_FAIL =
        '{ST_CRC_ERR, 8'h00, 7'd0, 16'h0000, 1'b0, 8'h00, 6'd0, 1'b1};

    // Empty frame behind a doubled sync byte, resync after a lone first sync byte, then a bad CRC
    localparam script_row_t SCRIPT [26] = '{
        '{KIND_DATA,   SRC_LIT,        8'h00, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'hA5, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'hA5, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'h5A, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'h02, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'hFF, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'h00, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'h00, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'hFF, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'hFF, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_CRC_LO,     8'h00, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_CRC_HI,     8'h00, 1'b1, EMPTY_FRAME_FF},
        '{KIND_DATA,   SRC_LIT,        8'hA5, 1'b0, NO_RESULT},
        '{KIND_RESYNC, SRC_LIT,        8'hFF, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'h5A, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'hA5, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'h5A, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'h02, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'h00, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'h01, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'h00, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'h00, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'h00, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_LIT,        8'h80, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_CRC_LO_BAD, 8'h00, 1'b0, NO_RESULT},
        '{KIND_DATA,   SRC_CRC_HI,     8'h00, 1'b1, CRC_FAIL}
    };

    logic clk;
    logic rst_n;

    cfd_in_if  rx ();
    cfd_out_if tx ();
    cfd_cfg_if cfg ();

    crc16_frame_deframer_core #(
        .MAX_PAYLOAD(PAYLOAD_CAP)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .tx    (tx),
        .cfg   (cfg)
    );

    // Register copies and parser state of the predictor
    logic [7:0]        want_version = VERSION_RST;
    logic [PLEN_W-1:0] max_len      = MAX_LEN_RST;
    ph_t               rx_phase     = PH_HUNT;
    logic [7:0]        body_mem [BODY_CAP];
    int                body_cnt     = 0;
    int                body_goal    = 0;
    logic [15:0]       crc_acc      = CRC_INIT;
    logic [7:0]        crc_lo_held  = 8'h00;

    deframed_t   awaited_out [$];
    logic [7:0]  frame_buf [$];
    int          err_count   = 0;
    int          frame_bytes = 0;
    bit          calm        = 1'b0;
    bit          hold_go     = 1'b0;
    longint      cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] ccitt_next(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] s;
        s = c;
        for (int i = 7; i >= 0; i--)
        begin
            if (s[15] ^ d[i])
            begin
                s = {s[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                s = {s[14:0], 1'b0};
            end
        end
        return s;
    endfunction

    function automatic int eff_limit();
        return (int'(max_len) > PAYLOAD_CAP) ? PAYLOAD_CAP : int'(max_len);
    endfunction

    function automatic void parser_idle();
        rx_phase    = PH_HUNT;
        body_cnt    = 0;
        body_goal   = 0;
        crc_acc     = CRC_INIT;
        crc_lo_held = 8'h00;
    endfunction

    // Advance the parser by one item and return the results it releases
    function automatic void deframe_item(input logic k, input logic [7:0] b,
                                         output deframed_t outs [$]);
        logic [15:0] len16;
        logic [15:0] seq16;
        int          n;
        deframed_t   r;
        outs = {};
        if (k == KIND_RESYNC)
        begin
            parser_idle();
            return;
        end
        case (rx_phase)
            PH_HUNT:
            begin
                if (b == SYNC_FIRST)
                begin
                    rx_phase = PH_SYNC;
                end
            end
            PH_SYNC:
            begin
                if (b == SYNC_SECOND)
                begin
                    rx_phase  = PH_BODY;
                    body_cnt  = 0;
                    body_goal = 0;
                    crc_acc   = CRC_INIT;
                end
                else if (b != SYNC_FIRST)
                begin
                    parser_idle();
                end
            end
            PH_BODY:
            begin
                if (body_cnt < BODY_CAP)
                begin
                    body_mem[body_cnt] = b;
                end
                body_cnt++;
                crc_acc = ccitt_next(crc_acc, b);
                if (body_cnt == 4)
                begin
                    len16 = {body_mem[POS_LEN_HI], body_mem[POS_LEN_LO]};
                    if (body_mem[POS_VERSION] != want_version || int'(len16) > eff_limit())
                    begin
                        parser_idle();
                        return;
                    end
                    body_goal = HEADER_LEN + int'(len16);
                end
                if (body_goal != 0 && body_cnt >= body_goal)
                begin
                    rx_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO:
            begin
                crc_lo_held = b;
                rx_phase    = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                if ({b, crc_lo_held} != crc_acc)
                begin
                    outs.push_back(CRC_FAIL);
                end
                else
                begin
                    len16 = {body_mem[POS_LEN_HI], body_mem[POS_LEN_LO]};
                    seq16 = {body_mem[POS_SEQ_HI], body_mem[POS_SEQ_LO]};
                    n     = (int'(len16) > PAYLOAD_CAP) ? PAYLOAD_CAP : int'(len16);
                    r     = '0;
                    r.status          = ST_GOOD;
                    r.msg_type        = body_mem[POS_TYPE];
                    r.sequence_number = seq16;
                    r.pay_len         = PLEN_W'(n);
                    if (n == 0)
                    begin
                        r.last = 1'b1;
                        outs.push_back(r);
                    end
                    for (int i = 0; i < n; i++)
                    begin
                        r.payload_valid = 1'b1;
                        r.payload_byte  = body_mem[HEADER_LEN + i];
                        r.byte_index    = IDX_W'(i);
                        r.last          = (i == n - 1);
                        outs.push_back(r);
                    end
                end
                parser_idle();
            end
            default:
            begin
                parser_idle();
            end
        endcase
    endfunction

    task automatic send_item(input logic k, input logic [7:0] b,
                             input logic fixed = 1'b0, input deframed_t want = '0);
        deframed_t made [$];
        int        gap;
        if (!calm && $urandom_range(0, 99) < 25)
        begin
            gap = $urandom_range(1, 3);
            rx.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx.valid     <= 1'b1;
        rx.kind      <= k;
        rx.data_byte <= b;
        @(posedge clk);
        while (!rx.ready) @(posedge clk);
        deframe_item(k, b, made);
        if (fixed)
        begin
            made = {want};
        end
        foreach (made[i]) awaited_out.push_back(made[i]);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        if (idx == REG_EXPECTED_VERSION)
        begin
            want_version = val;
        end
        else
        begin
            max_len = val[PLEN_W-1:0];
        end
    endtask

    task automatic apply_settings(input logic [7:0] ver, input logic [PLEN_W-1:0] lim);
        write_reg(REG_EXPECTED_VERSION, ver);
        write_reg(REG_MAX_PAY_LEN, {1'b0, lim});
        cfg.valid <= 1'b0;
    endtask

    // Drop valid, wait for every outstanding result, then let the core settle
    task automatic drain();
        rx.valid <= 1'b0;
        while (awaited_out.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic void build_frame();
        logic [7:0]  ver;
        logic [15:0] len16;
        logic [15:0] seq16;
        logic [15:0] fcs;
        logic [7:0]  body [$];
        int          lim;
        int          r;
        int          n_pay;
        lim   = eff_limit();
        ver   = ($urandom_range(0, 99) < 90) ? want_version : 8'($urandom);
        r     = $urandom_range(0, 99);
        if (r < 70)
        begin
            len16 = 16'($urandom_range(0, (lim < 8) ? lim : 8));
        end
        else if (r < 88)
        begin
            len16 = 16'($urandom_range(0, lim));
        end
        else if (r < 94 && lim < PAYLOAD_CAP)
        begin
            len16 = 16'($urandom_range(lim + 1, PAYLOAD_CAP));
        end
        else
        begin
            len16 = 16'($urandom);
        end
        // Oversized frames are dropped early; send only a few trailing bytes
        n_pay = (int'(len16) <= PAYLOAD_CAP) ? int'(len16) : $urandom_range(0, 6);
        seq16 = 16'($urandom);
        body  = {ver, 8'($urandom), len16[7:0], len16[15:8], seq16[7:0], seq16[15:8]};
        repeat (n_pay) body.push_back(8'($urandom));
        fcs = CRC_INIT;
        foreach (body[i]) fcs = ccitt_next(fcs, body[i]);
        if ($urandom_range(0, 99) < 15)
        begin
            fcs ^= 16'($urandom_range(1, 65535));
        end
        frame_buf = {};
        if ($urandom_range(0, 9) == 0)
        begin
            frame_buf.push_back(SYNC_FIRST);
        end
        frame_buf.push_back(SYNC_FIRST);
        frame_buf.push_back(SYNC_SECOND);
        foreach (body[i]) frame_buf.push_back(body[i]);
        frame_buf.push_back(fcs[7:0]);
        frame_buf.push_back(fcs[15:8]);
    endfunction

    task automatic run_traffic(input int n_bytes);
        int goal;
        int r;
        int cut;
        goal = frame_bytes + n_bytes;
        while (frame_bytes < goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 72)
            begin
                build_frame();
                foreach (frame_buf[i]) send_item(KIND_DATA, frame_buf[i]);
                frame_bytes += frame_buf.size();
            end
            else if (r < 82)
            begin
                // Broken frame: cut short, followed by a resync half of the time
                build_frame();
                cut = $urandom_range(1, frame_buf.size() - 1);
                for (int i = 0; i < cut; i++) send_item(KIND_DATA, frame_buf[i]);
                frame_bytes += cut;
                if ($urandom_range(0, 1) == 1)
                begin
                    send_item(KIND_RESYNC, 8'($urandom));
                end
            end
            else if (r < 92)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    case ($urandom_range(0, 2))
                        0:       send_item(KIND_DATA, SYNC_FIRST);
                        1:       send_item(KIND_DATA, SYNC_SECOND);
                        default: send_item(KIND_DATA, 8'($urandom));
                    endcase
                end
            end
            else
            begin
                send_item(KIND_RESYNC, 8'($urandom));
            end
        end
    endtask

    initial
    begin
        script_row_t row;
        logic [7:0]  b;
        rst_n         <= 1'b0;
        rx.valid      <= 1'b0;
        rx.kind       <= KIND_DATA;
        rx.data_byte  <= 8'h00;
        cfg.valid     <= 1'b0;
        cfg.index     <= REG_EXPECTED_VERSION;
        cfg.data      <= 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (SCRIPT[i])
        begin
            row = SCRIPT[i];
            case (row.src)
                SRC_LIT:    b = row.lit;
                SRC_CRC_LO: b = crc_acc[7:0];
                SRC_CRC_HI: b = crc_acc[15:8];
                default:    b = ~crc_acc[7:0];
            endcase
            send_item(row.kind, b, row.fixed, row.want);
        end
        drain();

        apply_settings(8'h00, 7'd0);
        run_traffic(55);
        drain();
        apply_settings(8'hFF, 7'd127);
        run_traffic(65);
        drain();
        calm = 1'b1;
        apply_settings(8'h5A, 7'd10);
        run_traffic(55);
        drain();
        calm = 1'b0;
        apply_settings(VERSION_RST, MAX_LEN_RST);
        // Hold the result side off while this traffic keeps coming
        hold_go = 1'b1;
        run_traffic(75);
        drain();
        apply_settings(8'($urandom), 7'($urandom_range(0, 127)));
        run_traffic(75);
        drain();

        if (err_count == 0)
        begin
            $display("PASS crc16_frame_deframer_core");
        end
        else
        begin
            $display("FAIL crc16_frame_deframer_core");
        end
        $finish;
    end

    // Result-side back-pressure, with one long hold-off once traffic is under way
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        tx.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && hold_go)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                tx.ready <= 1'b0;
            end
            else
            begin
                tx.ready <= calm || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            err_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        deframed_t want;
        if (rst_n && tx.valid && tx.ready)
        begin
            if (awaited_out.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result: expected none, actual byte %0h idx %0d",
                         $time, tx.payload_byte, tx.byte_index);
            end
            else
            begin
                want = awaited_out.pop_front();
                check_field("status", want.status, tx.status);
                check_field("msg_type", want.msg_type, tx.msg_type);
                check_field("pay_len", want.pay_len, tx.pay_len);
                check_field("sequence_number", want.sequence_number, tx.sequence_number);
                check_field("payload_valid", want.payload_valid, tx.payload_valid);
                check_field("payload_byte", want.payload_byte, tx.payload_byte);
                check_field("byte_index", want.byte_index, tx.byte_index);
                check_field("last", want.last, tx.last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, awaited_out.size());
            $display("FAIL crc16_frame_deframer_core");
            $finish;
        end
    end

endmodule
